/* design/bcfs_pkg.sv */
// ----------------------------------------------------------------------------
// bcfs_pkg
// shared types and constants for the 1bpp cover-fit image scaler
// ----------------------------------------------------------------------------
package bcfs_pkg;

    localparam int SOURCE_BYTES_DEF       = 8192;
    localparam int MAX_DEST_BYTES_PER_ROW = 80;
    localparam int QUEUE_DEPTH            = 4;
    localparam int DIV_W                  = 40;  // dividend bits, eight per step
    localparam int DIV_STEPS              = DIV_W / 8;
    localparam int SADDR_W                = 21;  // sampled source byte address
    localparam logic [7:0] BYTE_WHITE     = 8'hFF;
    localparam logic [2:0] LAST_BIT       = 3'd7;

    typedef enum logic [1:0] {
        CFG_SRC_W = 2'd0,
        CFG_SRC_H = 2'd1,
        CFG_DST_W = 2'd2,
        CFG_DST_H = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [10:0] src_w;
        logic [10:0] src_h;
        logic [9:0]  dst_w;
        logic [10:0] dst_h;
    } t_cfg;

    typedef enum logic [1:0] {
        K_LOAD = 2'd0,
        K_REQ  = 2'd1,
        K_ERR  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [12:0] addr;
        logic [7:0]  data;
        logic [9:0]  row;
        logic [6:0]  col;
    } t_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_CROP,
        S_CROPW,
        S_SYM,
        S_SYD,
        S_SYW,
        S_BASE,
        S_PX,
        S_PXD,
        S_PXW,
        S_RD,
        S_RDW,
        S_OUT
    } t_state;

endpackage

/* design/bitmap_cover_fit_scaler.sv */
// ----------------------------------------------------------------------------
// bitmap_cover_fit_scaler
// 1bpp nearest-neighbor scaler with aspect-preserving centered crop
// ----------------------------------------------------------------------------
// channel   | direction | handshake          | payload
// s_*       | in        | s_tvalid/s_tready  | tuser mode, tdata load/request
// m_*       | out       | m_tvalid/m_tready  | tdata pixel byte, tuser error
// i_cfg_*   | in        | i_cfg_we           | index, data
//
// a load is written to the source store by the sequencer from its idle state; a request
// with all eight pixels inside the width runs ten divider passes plus up to eight
// store reads; a padding pixel skips its divider pass and its store read
// requests outside the frame go straight to the output register
// the queue keeps accepting, until full, while a result waits on m_tready
// reset clears control only; the source store holds garbage until written
// ----------------------------------------------------------------------------
module bitmap_cover_fit_scaler #(
    parameter int SOURCE_BYTES = bcfs_pkg::SOURCE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // load_address, load_byte, out_row, out_column
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // pixel_byte
    output logic        m_tuser,   // out_of_range
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);

    bcfs_pkg::t_cfg  r_cfg;
    bcfs_pkg::t_item push_item;
    bcfs_pkg::t_item head_item;
    logic            push;
    logic            full;
    logic            head_valid;
    logic            pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_w <= 11'd80;
            r_cfg.src_h <= 11'd80;
            r_cfg.dst_w <= 10'd80;
            r_cfg.dst_h <= 11'd80;
        end else if (i_cfg_we) begin
            unique case (bcfs_pkg::t_cfg_idx'(i_cfg_index))
                bcfs_pkg::CFG_SRC_W: r_cfg.src_w <= i_cfg_data;
                bcfs_pkg::CFG_SRC_H: r_cfg.src_h <= i_cfg_data;
                bcfs_pkg::CFG_DST_W: r_cfg.dst_w <= i_cfg_data[9:0];
                bcfs_pkg::CFG_DST_H: r_cfg.dst_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bcfs_front #(.SOURCE_BYTES(SOURCE_BYTES)) u_front (
        .i_cfg   (r_cfg),
        .i_valid (s_tvalid),
        .i_mode  (s_tuser),
        .i_addr  (s_tdata[12:0]),
        .i_data  (s_tdata[20:13]),
        .i_row   (s_tdata[30:21]),
        .i_col   (s_tdata[37:31]),
        .i_full  (full),
        .o_ready (s_tready),
        .o_push  (push),
        .o_item  (push_item)
    );

    bcfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_item  (head_item)
    );

    bcfs_back #(.SOURCE_BYTES(SOURCE_BYTES)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (head_valid),
        .i_item  (head_item),
        .o_pop   (pop),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_byte  (m_tdata),
        .o_err   (m_tuser)
    );

endmodule

/* design/bcfs_div.sv */
// ----------------------------------------------------------------------------
// bcfs_div
// iterative unsigned divider, eight quotient bits per cycle
// ----------------------------------------------------------------------------
module bcfs_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [bcfs_pkg::DIV_W-1:0] i_num,
    input  logic [10:0]               i_den,
    output logic                      o_done,
    output logic [bcfs_pkg::DIV_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(bcfs_pkg::DIV_STEPS + 1);

    logic                       r_busy;
    logic                       r_done;
    logic [CNT_W-1:0]           r_cnt;
    logic [11:0]                r_rem;
    logic [10:0]                r_den;
    logic [bcfs_pkg::DIV_W-1:0] r_q;
    logic [11:0]                n_rem;
    logic [7:0]                 n_bits;

    always_comb begin
        logic [11:0] rem;
        rem = r_rem;
        for (int i = 0; i < 8; i++) begin
            rem = {rem[10:0], r_q[bcfs_pkg::DIV_W-1-i]};
            if (rem >= {1'b0, r_den}) begin
                rem          = rem - {1'b0, r_den};
                n_bits[7-i]  = 1'b1;
            end else begin
                n_bits[7-i]  = 1'b0;
            end
        end
        n_rem = rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(bcfs_pkg::DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[bcfs_pkg::DIV_W-9:0], n_bits};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

/* design/bcfs_queue.sv */
// ----------------------------------------------------------------------------
// bcfs_queue
// short register queue between the classifier and the execution sequencer
// ----------------------------------------------------------------------------
module bcfs_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  bcfs_pkg::t_item       i_item,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_valid,
    output bcfs_pkg::t_item       o_item
);

    localparam int PTR_W = $clog2(bcfs_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(bcfs_pkg::QUEUE_DEPTH + 1);

    bcfs_pkg::t_item  r_mem [bcfs_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_full  = (r_count == CNT_W'(bcfs_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rp];
    assign push    = i_push && !o_full;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_count <= r_count + CNT_W'(push) - CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_item;
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full || !push)
        else $error("queue push while full");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(bcfs_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
        r_count == $past(r_count) + CNT_W'($past(push)) - CNT_W'($past(pop)))
        else $error("queue count out of step");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wp == r_rp))
        else $error("queue pointers disagree with empty count");
`endif

endmodule

/* design/bcfs_front.sv */
// ----------------------------------------------------------------------------
// bcfs_front
// request classifier: drops stray loads, flags degenerate geometry and requests outside the frame
// ----------------------------------------------------------------------------
module bcfs_front #(
    parameter int SOURCE_BYTES = bcfs_pkg::SOURCE_BYTES_DEF
) (
    input  bcfs_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    input  logic            i_mode,
    input  logic [12:0]     i_addr,
    input  logic [7:0]      i_data,
    input  logic [9:0]      i_row,
    input  logic [6:0]      i_col,
    input  logic            i_full,
    output logic            o_ready,
    output logic            o_push,
    output bcfs_pkg::t_item o_item
);

    logic [7:0] dest_pitch;
    logic       degenerate;
    logic       outside;
    logic       keep;

    assign dest_pitch = 8'((11'(i_cfg.dst_w) + 11'd7) >> 3);
    assign degenerate = (i_cfg.src_w == '0) || (i_cfg.src_h == '0) ||
                        (i_cfg.dst_w == '0) || (i_cfg.dst_h == '0) ||
                        (32'(dest_pitch) > 32'(bcfs_pkg::MAX_DEST_BYTES_PER_ROW));
    assign outside    = (11'(i_row) >= i_cfg.dst_h) || (8'(i_col) >= dest_pitch);
    assign keep       = i_mode || (32'(i_addr) < 32'(SOURCE_BYTES));

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full && keep;

    always_comb begin
        o_item.addr = i_addr;
        o_item.data = i_data;
        o_item.row  = i_row;
        o_item.col  = i_col;
        if (!i_mode)
            o_item.kind = bcfs_pkg::K_LOAD;
        else if (degenerate || outside)
            o_item.kind = bcfs_pkg::K_ERR;
        else
            o_item.kind = bcfs_pkg::K_REQ;
    end

endmodule

/* design/bcfs_back.sv */
// ----------------------------------------------------------------------------
// bcfs_back
// execution sequencer: source store writes and per-byte nearest sampling
// ----------------------------------------------------------------------------
module bcfs_back #(
    parameter int SOURCE_BYTES = bcfs_pkg::SOURCE_BYTES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bcfs_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    input  bcfs_pkg::t_item i_item,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_byte,
    output logic            o_err
);

    localparam int AW = $clog2(SOURCE_BYTES);
    localparam int DW = bcfs_pkg::DIV_W;
    localparam int SADDR_WL = bcfs_pkg::SADDR_W;

    bcfs_pkg::t_state r_state;
    bcfs_pkg::t_state n_state;

    logic [7:0]  r_store [SOURCE_BYTES];
    logic [7:0]  r_rdata;
    logic [9:0]  r_row;
    logic [6:0]  r_col;
    logic [20:0] r_pa;
    logic [21:0] r_pb;
    logic        r_wide;
    logic [20:0] r_crop;
    logic [32:0] r_num;
    logic [10:0] r_sy;
    logic [19:0] r_base;
    logic [2:0]  r_k;
    logic [SADDR_WL-1:0] r_addr;
    logic [2:0]  r_bit;
    logic        r_oob;
    logic [7:0]  r_res;
    logic        r_rerr;
    logic        r_ovalid;
    logic [7:0]  r_obyte;
    logic        r_oerr;

    logic          div_start;
    logic [DW-1:0] div_num;
    logic [10:0]   div_den;
    logic          div_done;
    logic [DW-1:0] div_q;
    logic          mem_we;
    logic          mem_re;
    logic          out_load;
    logic          wide_now;
    logic [8:0]    src_pitch;
    logic [9:0]    dx;
    logic          dx_pad;
    logic [21:0]   crop_diff;
    logic [10:0]   sx;

    assign wide_now   = ({1'b0, r_pa} >= r_pb);
    assign src_pitch  = 9'((12'(i_cfg.src_w) + 12'd7) >> 3);
    assign dx         = {r_col, 3'b000} + 10'(r_k);
    assign dx_pad     = (dx >= i_cfg.dst_w);
    assign crop_diff  = div_q[21:0] - (r_wide ? 22'(i_cfg.dst_h) : 22'(i_cfg.dst_w));
    assign sx         = (div_q >= DW'(i_cfg.src_w)) ? (i_cfg.src_w - 11'd1) : div_q[10:0];
    assign out_load   = (r_state == bcfs_pkg::S_OUT) && (!r_ovalid || i_ready);

    always_comb begin
        div_num = DW'(r_num);
        div_den = r_wide ? 11'(i_cfg.dst_w) : i_cfg.dst_h;
        if (r_state == bcfs_pkg::S_CROP) begin
            div_num = wide_now ? DW'(r_pa) : DW'(r_pb);
            div_den = wide_now ? i_cfg.src_w : i_cfg.src_h;
        end
    end

    bcfs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_q)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bcfs_pkg::S_IDLE: begin
                if (i_valid) begin
                    unique case (i_item.kind)
                        bcfs_pkg::K_REQ: n_state = bcfs_pkg::S_MUL;
                        bcfs_pkg::K_ERR: n_state = bcfs_pkg::S_OUT;
                        default:         n_state = bcfs_pkg::S_IDLE;
                    endcase
                end
            end
            bcfs_pkg::S_MUL:   n_state = bcfs_pkg::S_CROP;
            bcfs_pkg::S_CROP:  n_state = bcfs_pkg::S_CROPW;
            bcfs_pkg::S_CROPW: if (div_done) n_state = bcfs_pkg::S_SYM;
            bcfs_pkg::S_SYM:   n_state = bcfs_pkg::S_SYD;
            bcfs_pkg::S_SYD:   n_state = bcfs_pkg::S_SYW;
            bcfs_pkg::S_SYW:   if (div_done) n_state = bcfs_pkg::S_BASE;
            bcfs_pkg::S_BASE:  n_state = bcfs_pkg::S_PX;
            bcfs_pkg::S_PX: begin
                if (!dx_pad)
                    n_state = bcfs_pkg::S_PXD;
                else if (r_k == bcfs_pkg::LAST_BIT)
                    n_state = bcfs_pkg::S_OUT;
            end
            bcfs_pkg::S_PXD:   n_state = bcfs_pkg::S_PXW;
            bcfs_pkg::S_PXW:   if (div_done) n_state = bcfs_pkg::S_RD;
            bcfs_pkg::S_RD:    n_state = bcfs_pkg::S_RDW;
            bcfs_pkg::S_RDW: begin
                n_state = (r_k == bcfs_pkg::LAST_BIT) ? bcfs_pkg::S_OUT : bcfs_pkg::S_PX;
            end
            bcfs_pkg::S_OUT:   if (out_load) n_state = bcfs_pkg::S_IDLE;
            default:           n_state = bcfs_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop     = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        div_start = 1'b0;
        unique case (r_state)
            bcfs_pkg::S_IDLE: begin
                o_pop  = i_valid;
                mem_we = i_valid && (i_item.kind == bcfs_pkg::K_LOAD);
            end
            bcfs_pkg::S_CROP,
            bcfs_pkg::S_SYD,
            bcfs_pkg::S_PXD:  div_start = 1'b1;
            bcfs_pkg::S_RD:   mem_re    = (32'(r_addr) < 32'(SOURCE_BYTES));
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bcfs_pkg::S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load)
                r_ovalid <= 1'b1;
            else if (i_ready)
                r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_store[AW'(i_item.addr)] <= i_item.data;
        if (mem_re) r_rdata <= r_store[r_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_obyte <= r_res;
            r_oerr  <= r_rerr;
        end
        case (r_state)
            bcfs_pkg::S_IDLE: begin
                r_row  <= i_item.row;
                r_col  <= i_item.col;
                r_res  <= bcfs_pkg::BYTE_WHITE;
                r_rerr <= (i_item.kind == bcfs_pkg::K_ERR);
                r_k    <= '0;
            end
            bcfs_pkg::S_MUL: begin
                r_pa <= 21'(i_cfg.dst_w) * 21'(i_cfg.src_h);
                r_pb <= 22'(i_cfg.dst_h) * 22'(i_cfg.src_w);
            end
            bcfs_pkg::S_CROP:  r_wide <= wide_now;
            bcfs_pkg::S_CROPW: if (div_done) r_crop <= crop_diff[21:1];
            bcfs_pkg::S_SYM: begin
                if (r_wide)
                    r_num <= (33'(r_row) + 33'(r_crop)) * 33'(i_cfg.src_w);
                else
                    r_num <= 33'(r_row) * 33'(i_cfg.src_h);
            end
            bcfs_pkg::S_SYW: begin
                if (div_done)
                    r_sy <= (div_q >= DW'(i_cfg.src_h)) ? (i_cfg.src_h - 11'd1)
                                                        : div_q[10:0];
            end
            bcfs_pkg::S_BASE: r_base <= 20'(r_sy) * 20'(src_pitch);
            bcfs_pkg::S_PX: begin
                if (r_wide)
                    r_num <= 33'(dx) * 33'(i_cfg.src_w);
                else
                    r_num <= (33'(dx) + 33'(r_crop)) * 33'(i_cfg.src_h);
                if (dx_pad) r_k <= r_k + 3'd1;
            end
            bcfs_pkg::S_PXW: begin
                if (div_done) begin
                    r_addr <= SADDR_WL'(r_base) + SADDR_WL'(sx[10:3]);
                    r_bit  <= sx[2:0];
                end
            end
            bcfs_pkg::S_RD: r_oob <= !mem_re;
            bcfs_pkg::S_RDW: begin
                if (!r_oob && !r_rdata[bcfs_pkg::LAST_BIT - r_bit])
                    r_res[bcfs_pkg::LAST_BIT - r_k] <= 1'b0;
                r_k <= r_k + 3'd1;
            end
            default: ;
        endcase
    end

    assign o_valid = r_ovalid;
    assign o_byte  = r_obyte;
    assign o_err   = r_oerr;

`ifndef SYNTH
    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> !div_done)
        else $error("divider done right after start");
    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == bcfs_pkg::S_IDLE) && i_valid)
        else $error("queue pop outside idle");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_ready) |=> r_ovalid && $stable(r_obyte))
        else $error("result lost under stall");
`endif

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks the 1bpp cover-fit scaler against a built-in pixel predictor: loads
// and destination-byte requests are streamed with random gaps and backpressure
// across several frame geometries, including degenerate and extreme ones
// ----------------------------------------------------------------------------
module testbench;

    typedef struct {
        bit          mode;
        logic [12:0] addr;
        logic [7:0]  data;
        logic [9:0]  row;
        logic [6:0]  col;
    } t_req;

    typedef struct {
        logic [7:0] pix;
        logic       oor;
    } t_px_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // load_address, load_byte, out_row, out_column
    logic        s_tuser = 1'b0; // mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // pixel_byte
    logic        m_tuser;        // out_of_range
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [10:0] i_cfg_data = '0;

    bitmap_cover_fit_scaler u_top (.*);

    always #5 i_clk = ~i_clk;

    // scaler geometry as the block sees it
    int unsigned src_w = 80, src_h = 80, dst_w = 80, dst_h = 80;
    logic [7:0]  img [bcfs_pkg::SOURCE_BYTES_DEF];
    bit          gen_written [bcfs_pkg::SOURCE_BYTES_DEF];
    int unsigned blank_addrs [$];

    t_req    pending [$];
    t_px_out pixel_bytes_due [$];
    t_req    cur;
    bit      calm = 1'b0;
    bit      hold_req = 1'b0;
    int      gap_left = 0, stall_left = 0, hold_left = 0;
    int      fails = 0, total_items = 0, n_loads = 0, n_reqs = 0, n_oor = 0, n_phases = 0;
    int      quiet = 0;

    // packed destination byte with error flag; in probe mode lists unwritten reads
    function automatic logic [8:0] fit_byte(logic [9:0] row, logic [6:0] col, bit probe);
        longint unsigned sw, sh, dw, dh, ss, ds, cy, cx, sy, sx, dx, a;
        bit wide;
        logic [7:0] res;
        sw = src_w; sh = src_h; dw = dst_w; dh = dst_h;
        cy = 0; cx = 0;
        if (sw == 0 || sh == 0 || dw == 0 || dh == 0) return {bcfs_pkg::BYTE_WHITE, 1'b1};
        ss = (sw + 7) / 8;
        ds = (dw + 7) / 8;
        if (ds > bcfs_pkg::MAX_DEST_BYTES_PER_ROW) return {bcfs_pkg::BYTE_WHITE, 1'b1};
        if (row >= dh || col >= ds) return {bcfs_pkg::BYTE_WHITE, 1'b1};
        wide = dw * sh >= dh * sw;
        if (wide) cy = ((sh * dw / sw) - dh) / 2;
        else cx = ((sw * dh / sh) - dw) / 2;
        sy = wide ? (row + cy) * sw / dw : row * sh / dh;
        if (sy > sh - 1) sy = sh - 1;
        res = bcfs_pkg::BYTE_WHITE;
        for (int k = 0; k < 8; k++) begin
            dx = col * 8 + k;
            if (dx < dw) begin
                sx = wide ? dx * sw / dw : (dx + cx) * sh / dh;
                if (sx > sw - 1) sx = sw - 1;
                a = sy * ss + (sx >> 3);
                if (a < bcfs_pkg::SOURCE_BYTES_DEF) begin
                    if (probe) begin
                        if (!gen_written[a])
                            blank_addrs.insert(blank_addrs.size(), 32'(a));
                    end else if (img[a][bcfs_pkg::LAST_BIT - sx[2:0]] == 1'b0) begin
                        res[bcfs_pkg::LAST_BIT - k] = 1'b0;
                    end
                end
            end
        end
        return {res, 1'b0};
    endfunction

    task automatic push_load(int unsigned addr, logic [7:0] data);
        t_req r;
        r = '{mode: 1'b0, addr: addr[12:0], data: data, row: 10'($urandom),
              col: 7'($urandom)};
        gen_written[addr] = 1'b1;
        pending.insert(pending.size(), r);
        total_items++;
    endtask

    // loads any unwritten source bytes the request would sample, then the request itself
    task automatic push_request(logic [9:0] row, logic [6:0] col);
        t_req r;
        logic [8:0] unused;
        blank_addrs.delete();
        unused = fit_byte(row, col, 1'b1);
        foreach (blank_addrs[i])
            if (!gen_written[blank_addrs[i]]) push_load(blank_addrs[i], 8'($urandom));
        r = '{mode: 1'b1, addr: 13'($urandom), data: 8'($urandom), row: row, col: col};
        pending.insert(pending.size(), r);
        total_items++;
    endtask

    task automatic cfg_write(bcfs_pkg::t_cfg_idx idx, int unsigned val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[10:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            bcfs_pkg::CFG_SRC_W: src_w = val & 11'h7FF;
            bcfs_pkg::CFG_SRC_H: src_h = val & 11'h7FF;
            bcfs_pkg::CFG_DST_W: dst_w = val & 10'h3FF;
            default:             dst_h = val & 11'h7FF;
        endcase
    endtask

    task automatic drain();
        while (pending.size() != 0 || s_tvalid || pixel_bytes_due.size() != 0)
            @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic run_phase(int unsigned sw, int unsigned sh, int unsigned dw,
                             int unsigned dh, int n);
        int unsigned ss, ds, region, start, row_max, col_max, bulk;
        drain();
        cfg_write(bcfs_pkg::CFG_SRC_W, sw);
        cfg_write(bcfs_pkg::CFG_SRC_H, sh);
        cfg_write(bcfs_pkg::CFG_DST_W, dw);
        cfg_write(bcfs_pkg::CFG_DST_H, dh);
        n_phases++;
        ss = (src_w + 7) / 8;
        ds = (dst_w + 7) / 8;
        region = ss * src_h;
        if (region > bcfs_pkg::SOURCE_BYTES_DEF) region = bcfs_pkg::SOURCE_BYTES_DEF;
        if (region > 0) begin
            bulk = region < 48 ? region : 48;
            start = $urandom_range(0, region - bulk);
            for (int i = 0; i < bulk; i++) push_load(start + i, 8'($urandom));
        end
        row_max = (dst_h == 0) ? 1023 : (dst_h > 1024 ? 1023 : dst_h - 1);
        col_max = (ds == 0) ? 127 : (ds > 128 ? 127 : ds - 1);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                push_load($urandom_range(0, bcfs_pkg::SOURCE_BYTES_DEF - 1), 8'($urandom));
            end else begin
                push_request($urandom_range(0, 9) < 8 ? $urandom_range(0, row_max)
                                                       : $urandom_range(0, 1023),
                             $urandom_range(0, 9) < 8 ? $urandom_range(0, col_max)
                                                       : $urandom_range(0, 127));
            end
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            gap_left <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                if (cur.mode == 1'b0) begin
                    img[cur.addr] = cur.data;
                    n_loads++;
                end else begin
                    logic [8:0] p;
                    p = fit_byte(cur.row, cur.col, 1'b0);
                    pixel_bytes_due.insert(pixel_bytes_due.size(),
                                           '{pix: p[8:1], oor: p[0]});
                    n_reqs++;
                end
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pending.size() != 0) begin
                cur = pending.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= cur.mode;
                s_tdata <= {2'b00, cur.col, cur.row, cur.data, cur.addr};
                if (!calm && $urandom_range(0, 7) == 0) gap_left <= $urandom_range(1, 8);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pixel_bytes_due.size() == 0) begin
                    $error("unexpected result pixel_byte=%h out_of_range=%b", m_tdata, m_tuser);
                    fails++;
                end else begin
                    t_px_out e;
                    e = pixel_bytes_due.pop_front();
                    if (m_tdata !== e.pix) begin
                        $error("pixel_byte expected %h actual %h", e.pix, m_tdata);
                        fails++;
                    end
                    if (m_tuser !== e.oor) begin
                        $error("out_of_range expected %b actual %b", e.oor, m_tuser);
                        fails++;
                    end
                    if (e.oor) n_oor++;
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left <= 600;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 8);
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || i_cfg_we || !i_rst_n)
            quiet <= 0;
        else if (quiet >= 4000) begin
            $display("bitmap_cover_fit_scaler regression: fail");
            $finish;
        end else
            quiet <= quiet + 1;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes at the reset geometry
        push_load(0, 8'h00);
        push_load(bcfs_pkg::SOURCE_BYTES_DEF - 1, 8'hFF);
        push_load(0, 8'hFF);
        push_load(1, 8'h00);
        push_load(2, 8'hA5);
        push_request(0, 0);
        push_request(0, 1);
        push_request(79, 9);
        push_request(40, 5);
        push_request(80, 0);
        push_request(0, 10);
        push_request(1023, 127);
        push_request(0, 79);
        push_request(79, 0);
        push_load(bcfs_pkg::SOURCE_BYTES_DEF - 1, 8'h5A);

        // extreme and degenerate geometries
        run_phase(1, 1, 1, 1, 30);
        run_phase(1024, 1024, 640, 1024, 80);
        run_phase(2047, 2047, 640, 2047, 30);
        run_phase(0, 80, 80, 80, 8);
        run_phase(80, 0, 80, 80, 8);
        run_phase(80, 80, 0, 80, 8);
        run_phase(80, 80, 80, 0, 8);
        run_phase(80, 80, 1023, 80, 8);
        run_phase(80, 80, 641, 80, 8);
        run_phase(8, 200, 640, 4, 40);
        run_phase(1024, 3, 16, 900, 40);

        // random geometries; one phase backs up the output
        while (total_items < 1800) begin
            if (total_items > 1550) calm = 1'b1;
            if (n_phases == 14) hold_req = 1'b1;
            run_phase($urandom_range(0, 7) == 0 ? $urandom_range(1, 1024) : $urandom_range(1, 96),
                      $urandom_range(0, 7) == 0 ? $urandom_range(1, 1024) : $urandom_range(1, 96),
                      $urandom_range(0, 7) == 0 ? $urandom_range(1, 640) : $urandom_range(1, 160),
                      $urandom_range(0, 7) == 0 ? $urandom_range(1, 1024) : $urandom_range(1, 200),
                      $urandom_range(50, 110));
        end
        drain();

        if (pixel_bytes_due.size() != 0) begin
            $error("%0d pixel bytes never returned", pixel_bytes_due.size());
            fails++;
        end
        $display("covered %0d geometries, %0d source loads, %0d destination requests",
                 n_phases, n_loads, n_reqs);
        $display("%0d requests flagged out of range, %0d mismatches", n_oor, fails);
        if (fails == 0)
            $display("bitmap_cover_fit_scaler regression: pass");
        else
            $display("bitmap_cover_fit_scaler regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
design/bcfs_pkg.sv
design/bcfs_div.sv
design/bcfs_queue.sv
design/bcfs_front.sv
design/bcfs_back.sv
design/bitmap_cover_fit_scaler.sv
tb/testbench.sv
